// ===== sv/lstr_pkg.sv =====
`default_nettype none

package lstr_pkg;

    // Default build values
    localparam int COLUMNS_DEFAULT        = 128;
    localparam int LOG_INDEX_BITS_DEFAULT = 9;

    // Field widths
    localparam int COLUMN_W   = 7;
    localparam int SAMPLE_W   = 16;
    localparam int ROW_W      = 8;
    localparam int PIXEL_X_W  = 11;
    localparam int PIXEL_Y_W  = 10;
    localparam int ORIGIN_X_W = 10;
    localparam int ORIGIN_Y_W = 9;
    localparam int SIZE_W     = 8;
    localparam int HALF_W     = SIZE_W - 1;
    localparam int TABLE_W    = 16;

    // Largest column count the column field can address
    localparam int COLUMN_LIMIT = 1 << COLUMN_W;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_X     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_Y     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TRACE_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TRACE_HEIGHT = 2'd3;

    localparam logic [SIZE_W-1:0] TRACE_WIDTH_RESET  = 8'd128;
    localparam logic [SIZE_W-1:0] TRACE_HEIGHT_RESET = 8'd64;

    // Queue between row computation and pixel emission
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

    // Log curve fixed point
    localparam int FX_FRAC        = 59;
    localparam int LOG_FRAC_STEPS = 17;

    typedef struct packed {
        logic [COLUMN_W-1:0] col;
        logic [ROW_W-1:0]    row;
    } lstr_entry_t;

    // Log curve entry, evaluated at elaboration only:
    // min(65535, round(65536 * log10(1 + 9k / 2^index_bits)))
    // via a binary digit recurrence for log10 (square, compare to ten, scale down).
    function automatic logic [TABLE_W-1:0] log_value(int unsigned k, int unsigned index_bits);
        logic [63:0]  ten;
        logic [63:0]  y;
        logic [127:0] prod;
        logic [LOG_FRAC_STEPS:0] bits;
        ten  = 64'd10 << FX_FRAC;
        y    = (64'(64'd1 << index_bits) + 64'(9 * k)) << (FX_FRAC - index_bits);
        bits = '0;
        if (y >= ten) begin
            return {TABLE_W{1'b1}};
        end
        for (int i = 0; i < LOG_FRAC_STEPS; i++) begin
            prod = {64'd0, y} * {64'd0, y};
            y    = prod[FX_FRAC+63:FX_FRAC];
            bits = {bits[LOG_FRAC_STEPS-1:0], 1'b0};
            if (y >= ten) begin
                bits[0] = 1'b1;
                y       = y / 64'd10;
            end
        end
        bits = (bits + 1'b1) >> 1;
        if (bits > {TABLE_W{1'b1}}) begin
            return {TABLE_W{1'b1}};
        end
        return bits[TABLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/log_scope_trace_renderer.sv =====
// Log-scale scope trace renderer.
// Input channel (in_valid / in_stall): one item per sample, carrying the trace
// column and a signed 16-bit sample. An item is taken when in_valid is high and
// in_stall is low. Output channel (out_valid / out_stall): pixel writes. A sample
// whose row differs from the row last drawn in its column yields an erase pixel
// at the old row followed by a draw pixel (last = 1) at the new row; an unchanged
// row or a column beyond the drawn width yields nothing.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 origin_x,
// 1 origin_y, 2 trace_width, 3 trace_height; write only while idle.
// An item passes the stages s1, s2 and s3, the queue, the current-item register
// and the output register, where the erase pixel is offered; the draw pixel
// follows it. The single pixel output limits items that change a row; new items
// enter while earlier ones are in flight. A 4-entry queue between the row
// pipeline and the pixel emitter absorbs output stalls; in_stall rises once the
// queue and the three pipeline stages hold 4 items.
// Reset clears the registers to origin 0, width 128, height 64 and makes every
// column's stored row read as zero at once; no clearing pass is needed.
// A stalled output holds its pixel; the queue then fills and stalls the input.
`default_nettype none

module log_scope_trace_renderer #(
    parameter int COLUMNS        = lstr_pkg::COLUMNS_DEFAULT,
    parameter int LOG_INDEX_BITS = lstr_pkg::LOG_INDEX_BITS_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [lstr_pkg::COLUMN_W-1:0]         column,
    input  wire logic signed [lstr_pkg::SAMPLE_W-1:0]  sample,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [lstr_pkg::PIXEL_X_W-1:0]             pixel_x,
    output logic [lstr_pkg::PIXEL_Y_W-1:0]             pixel_y,
    output logic                                       paint_trace,
    output logic                                       last,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [lstr_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [lstr_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import lstr_pkg::*;

    logic [ORIGIN_X_W-1:0]    origin_x_reg;
    logic [ORIGIN_Y_W-1:0]    origin_y_reg;
    logic [SIZE_W-1:0]        trace_width_reg;
    logic [SIZE_W-1:0]        trace_height_reg;

    logic                     push_valid;
    lstr_entry_t              push_entry;
    logic                     pop;
    logic                     head_valid;
    lstr_entry_t              head_entry;
    logic [QUEUE_COUNT_W-1:0] queue_count;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            trace_width_reg  <= TRACE_WIDTH_RESET;
            trace_height_reg <= TRACE_HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X:     origin_x_reg     <= cfg_data[ORIGIN_X_W-1:0];
                REG_ORIGIN_Y:     origin_y_reg     <= cfg_data[ORIGIN_Y_W-1:0];
                REG_TRACE_WIDTH:  trace_width_reg  <= cfg_data[SIZE_W-1:0];
                REG_TRACE_HEIGHT: trace_height_reg <= cfg_data[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    lstr_front #(
        .COLUMNS        (COLUMNS),
        .LOG_INDEX_BITS (LOG_INDEX_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .column       (column),
        .sample       (sample),
        .trace_width  (trace_width_reg),
        .trace_height (trace_height_reg),
        .queue_count  (queue_count),
        .push_valid   (push_valid),
        .push_entry   (push_entry)
    );

    lstr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .count      (queue_count)
    );

    lstr_back #(
        .COLUMNS (COLUMNS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_entry  (head_entry),
        .pop         (pop),
        .origin_x    (origin_x_reg),
        .origin_y    (origin_y_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .paint_trace (paint_trace),
        .last        (last)
    );

endmodule

`default_nettype wire

// ===== sv/lstr_front.sv =====
`default_nettype none

module lstr_front #(
    parameter int COLUMNS        = lstr_pkg::COLUMNS_DEFAULT,
    parameter int LOG_INDEX_BITS = lstr_pkg::LOG_INDEX_BITS_DEFAULT
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [lstr_pkg::COLUMN_W-1:0]         column,
    input  wire logic signed [lstr_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic [lstr_pkg::SIZE_W-1:0]           trace_width,
    input  wire logic [lstr_pkg::SIZE_W-1:0]           trace_height,
    input  wire logic [lstr_pkg::QUEUE_COUNT_W-1:0]    queue_count,
    output logic                                       push_valid,
    output lstr_pkg::lstr_entry_t                      push_entry
);
    import lstr_pkg::*;

    localparam int LOG_ENTRIES = (1 << LOG_INDEX_BITS) + 1;
    localparam int K_W         = LOG_INDEX_BITS + 1;
    localparam int PROD_W      = HALF_W + TABLE_W;

    // Log curve ROM
    logic [TABLE_W-1:0] log_rom [LOG_ENTRIES];

    for (genvar g = 0; g < LOG_ENTRIES; g++) begin : g_log_rom
        localparam logic [TABLE_W-1:0] ENTRY = log_value(g, LOG_INDEX_BITS);
        assign log_rom[g] = ENTRY;
    end

    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [COLUMN_W-1:0] s1_col_reg, s2_col_reg, s3_col_reg;
    logic                s1_neg_reg, s2_neg_reg, s3_neg_reg;
    logic [K_W-1:0]      s1_k_reg;
    logic [TABLE_W-1:0]  s2_log_reg;
    logic [HALF_W-1:0]   s3_half_reg;
    logic [PROD_W-1:0]   s3_prod_reg;

    logic                  accept;
    logic [SAMPLE_W-1:0]   raw;
    logic [SAMPLE_W-1:0]   mag;
    logic                  in_range;
    logic [QUEUE_COUNT_W:0] load;
    logic [HALF_W-1:0]     offset;

    // Reserve queue space for every item in flight
    assign load = {1'b0, queue_count} + (QUEUE_COUNT_W + 1)'(s1_valid_reg)
                + (QUEUE_COUNT_W + 1)'(s2_valid_reg) + (QUEUE_COUNT_W + 1)'(s3_valid_reg);
    assign in_stall = (load >= (QUEUE_COUNT_W + 1)'(QUEUE_DEPTH));
    assign accept   = in_valid && !in_stall;

    // Classify: magnitude, table index, column range
    assign raw      = sample;
    assign mag      = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
    assign in_range = ({1'b0, column} < trace_width) && (32'(column) < COLUMNS);

    // Advance the valid bits; out-of-range items drop here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && in_range;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Table lookup and scaling by half height
    always_ff @(posedge clk)
    begin
        s1_col_reg  <= column;
        s1_neg_reg  <= raw[SAMPLE_W-1];
        s1_k_reg    <= mag[SAMPLE_W-1 -: K_W];
        s2_col_reg  <= s1_col_reg;
        s2_neg_reg  <= s1_neg_reg;
        s2_log_reg  <= log_rom[s1_k_reg];
        s3_col_reg  <= s2_col_reg;
        s3_neg_reg  <= s2_neg_reg;
        s3_half_reg <= trace_height[SIZE_W-1:1];
        s3_prod_reg <= trace_height[SIZE_W-1:1] * s2_log_reg;
    end

    // Form the row around the zero line
    assign offset           = s3_prod_reg[PROD_W-1:TABLE_W];
    assign push_valid       = s3_valid_reg;
    assign push_entry.col   = s3_col_reg;
    assign push_entry.row   = s3_neg_reg ? ({1'b0, s3_half_reg} - {1'b0, offset})
                                         : ({1'b0, s3_half_reg} + {1'b0, offset});

endmodule

`default_nettype wire

// ===== sv/lstr_queue.sv =====
`default_nettype none

module lstr_queue (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push_valid,
    input  wire lstr_pkg::lstr_entry_t              push_entry,
    input  wire logic                               pop,
    output logic                                    head_valid,
    output lstr_pkg::lstr_entry_t                   head_entry,
    output logic [lstr_pkg::QUEUE_COUNT_W-1:0]      count
);
    import lstr_pkg::*;

    lstr_entry_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_COUNT_W-1:0] count_reg;
    logic                     do_pop;

    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign count      = count_reg;
    assign do_pop     = pop && head_valid;

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_valid && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push_valid && do_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lstr_back.sv =====
`default_nettype none

module lstr_back #(
    parameter int COLUMNS = lstr_pkg::COLUMNS_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              head_valid,
    input  wire lstr_pkg::lstr_entry_t             head_entry,
    output logic                                   pop,
    input  wire logic [lstr_pkg::ORIGIN_X_W-1:0]   origin_x,
    input  wire logic [lstr_pkg::ORIGIN_Y_W-1:0]   origin_y,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [lstr_pkg::PIXEL_X_W-1:0]         pixel_x,
    output logic [lstr_pkg::PIXEL_Y_W-1:0]         pixel_y,
    output logic                                   paint_trace,
    output logic                                   last
);
    import lstr_pkg::*;

    localparam int ROW_DEPTH = (COLUMNS < COLUMN_LIMIT) ? COLUMNS : COLUMN_LIMIT;
    localparam int ADDR_W    = $clog2(ROW_DEPTH);

    // Previous row per column, with a written flag per entry
    logic [ROW_W-1:0]     row_mem [ROW_DEPTH];
    logic [ROW_DEPTH-1:0] row_known_reg;

    lstr_entry_t          cur_reg;
    logic                 cur_valid_reg;
    logic [ROW_W-1:0]     rd_row_reg;
    logic                 rd_known_reg;
    logic                 fwd_hit_reg;
    logic [ROW_W-1:0]     fwd_row_reg;

    logic                 out_valid_reg;
    logic                 pend_valid_reg;
    logic [PIXEL_X_W-1:0] out_x_reg;
    logic [PIXEL_Y_W-1:0] out_y_reg;
    logic                 out_paint_reg;
    logic [PIXEL_Y_W-1:0] pend_y_reg;

    logic [ADDR_W-1:0]    head_addr, cur_addr;
    logic [ROW_W-1:0]     old_row;
    logic                 same;
    logic                 out_free;
    logic                 emit_ok;
    logic                 cur_done;
    logic                 do_write;

    assign head_addr = ADDR_W'(head_entry.col);
    assign cur_addr  = ADDR_W'(cur_reg.col);

    // Compare against the stored row, forwarding a same-edge write
    assign old_row  = fwd_hit_reg ? fwd_row_reg : (rd_known_reg ? rd_row_reg : '0);
    assign same     = (old_row == cur_reg.row);
    assign out_free = !out_valid_reg || !out_stall;
    assign emit_ok  = out_free && !pend_valid_reg;
    assign cur_done = cur_valid_reg && (same || emit_ok);
    assign do_write = cur_valid_reg && !same && emit_ok;
    assign pop      = head_valid && (!cur_valid_reg || cur_done);

    // Row memory: write the new row, read the next column
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            row_mem[cur_addr] <= cur_reg.row;
        end
        if (pop)
        begin
            rd_row_reg   <= row_mem[head_addr];
            rd_known_reg <= row_known_reg[head_addr];
            fwd_hit_reg  <= do_write && (head_addr == cur_addr);
            fwd_row_reg  <= cur_reg.row;
            cur_reg      <= head_entry;
        end
    end

    // Mark written columns; reset reads back as row zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_known_reg <= '0;
        end
        else if (do_write)
        begin
            row_known_reg[cur_addr] <= 1'b1;
        end
    end

    // Advance the current item and the output slots
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
            end
            else if (cur_done)
            begin
                cur_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                if (pend_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    pend_valid_reg <= 1'b0;
                end
                else if (do_write)
                begin
                    out_valid_reg  <= 1'b1;
                    pend_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    // Load erase then draw pixels
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (pend_valid_reg)
            begin
                out_y_reg     <= pend_y_reg;
                out_paint_reg <= 1'b1;
            end
            else if (do_write)
            begin
                out_x_reg     <= PIXEL_X_W'(origin_x) + PIXEL_X_W'(cur_reg.col);
                out_y_reg     <= PIXEL_Y_W'(origin_y) + PIXEL_Y_W'(old_row);
                out_paint_reg <= 1'b0;
                pend_y_reg    <= PIXEL_Y_W'(origin_y) + PIXEL_Y_W'(cur_reg.row);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign paint_trace = out_paint_reg;
    assign last        = out_paint_reg;

    // A draw waits only behind its own erase
    a_pend_behind_erase: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (out_valid_reg && !out_paint_reg))
        else $error("pending draw without its erase in the output slot");

    // A taken erase is followed by the draw at the same column
    a_draw_follows_erase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !out_paint_reg)
        |=> (out_valid_reg && out_paint_reg && $stable(out_x_reg)))
        else $error("erase not followed by draw at the same column");

    // A same-column item right after a write sees the new row
    a_forward_row: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && do_write && (head_addr == cur_addr))
        |=> (fwd_hit_reg && (old_row == $past(cur_reg.row))))
        else $error("stored row not forwarded to the next item");

endmodule

`default_nettype wire
